// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the delay timer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/odts_pkg.sv =====
// Types and constants for the one-shot delay timer bank.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package odts_pkg;

	localparam int NUM_SLOTS_DEF   = 10;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int TASK_W          = 8;
	localparam int TICKS_W         = 32;
	localparam int SLOT_OUT_W      = 4;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ARM  = 1'b1
	} op_t;

	// Command word passed from the front end to the slot engine
	typedef struct packed {
		op_t                op;
		logic [TASK_W-1:0]  task_id;
		logic [TICKS_W-1:0] ticks;
	} cmd_t;

	// Queue status seen by both ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One slot as held in the slot memory
	typedef struct packed {
		logic [TASK_W-1:0]  task_id;
		logic [TICKS_W-1:0] ticks;
	} slot_word_t;

endpackage

// ===== rtl/odts_queue.sv =====
// Short command FIFO between the front end and the slot engine.
// Depends on odts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module odts_queue #(
	parameter int DEPTH = odts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  odts_pkg::cmd_t   push_cmd,
	input  logic             pop,
	output odts_pkg::cmd_t   head,
	output odts_pkg::q_stat_t q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	odts_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_IMPL(a_q_no_overflow, clk, arst_n, push, !q_stat.full, "push into full queue")
	`ASSERT_IMPL(a_q_no_underflow, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/odts_front.sv =====
// Front end: enable register, input acceptance and command classification.
// Depends on odts_pkg.
`timescale 1ns / 1ps

module odts_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          timer_enable,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [odts_pkg::TASK_W-1:0]   task_id,
	input  logic [odts_pkg::TICKS_W-1:0]  delay_ticks,
	input  odts_pkg::q_stat_t             q_stat,
	output logic                          push,
	output odts_pkg::cmd_t                push_cmd
);

	logic enable_q;
	logic accept;
	logic is_arm;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign is_arm    = (odts_pkg::op_t'(mode) == odts_pkg::OP_ARM);

	// Drop ticks while disabled; arms always go through
	assign push = accept && (is_arm || enable_q);

	always_comb begin
		push_cmd.op      = odts_pkg::op_t'(mode);
		push_cmd.task_id = task_id;
		// A zero count expires on the next tick
		push_cmd.ticks   = (delay_ticks == '0) ? odts_pkg::TICKS_W'(1) : delay_ticks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= timer_enable;
		end
	end

endmodule

// ===== rtl/odts_back.sv =====
// Slot engine: slot memory, active bits, serial tick scan and result register.
// Depends on odts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module odts_back #(
	parameter int NUM_SLOTS = odts_pkg::NUM_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  odts_pkg::cmd_t                  head,
	input  odts_pkg::q_stat_t               q_stat,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [odts_pkg::TASK_W-1:0]     expired_task,
	output logic [odts_pkg::SLOT_OUT_W-1:0] expired_slot,
	output logic                            last_expiry
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t                        state_q;
	odts_pkg::slot_word_t          slot_mem [NUM_SLOTS];
	odts_pkg::slot_word_t          rd_s1;
	logic [NUM_SLOTS-1:0]          active_q;
	logic [SLOT_W-1:0]             next_slot_q;
	logic [SLOT_W-1:0]             rd_ptr_q;
	logic [SLOT_W-1:0]             idx_s1;
	logic [CNT_W-1:0]              issued_q;
	logic                          hold_v_q;
	logic [odts_pkg::TASK_W-1:0]   hold_task_q;
	logic [SLOT_W-1:0]             hold_slot_q;
	logic                          out_v_q;
	logic [odts_pkg::TASK_W-1:0]   out_task_q;
	logic [odts_pkg::SLOT_OUT_W-1:0] out_slot_q;
	logic                          out_last_q;

	logic                          is_arm;
	logic                          cur_active;
	logic                          expire;
	logic                          out_free;
	logic                          scan_go;
	logic                          scan_more;
	logic                          flush_emit;
	logic                          out_load;
	logic                          wr_en;
	logic [SLOT_W-1:0]             wr_addr;
	odts_pkg::slot_word_t          wr_data;
	logic                          rd_en;
	logic [SLOT_W-1:0]             rd_addr;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
		return (p == SLOT_W'(NUM_SLOTS - 1)) ? '0 : p + SLOT_W'(1);
	endfunction

	assign is_arm     = (head.op == odts_pkg::OP_ARM);
	assign pop        = (state_q == ST_IDLE) && !q_stat.empty;
	assign cur_active = active_q[idx_s1];
	// Active slots never hold zero, so reaching zero means holding one now
	assign expire     = (state_q == ST_SCAN) && cur_active
	                    && (rd_s1.ticks == odts_pkg::TICKS_W'(1));
	assign out_free   = !out_v_q || out_ready;
	assign scan_go    = (state_q == ST_SCAN) && (!(expire && hold_v_q) || out_free);
	assign scan_more  = (issued_q != CNT_W'(NUM_SLOTS));
	assign flush_emit = (state_q == ST_FLUSH) && hold_v_q && out_free;
	assign out_load   = (scan_go && expire && hold_v_q) || flush_emit;

	always_comb begin
		wr_en   = (pop && is_arm) || (scan_go && cur_active);
		rd_en   = (pop && !is_arm) || (scan_go && scan_more);
		wr_addr = idx_s1;
		rd_addr = rd_ptr_q;
		wr_data.task_id = rd_s1.task_id;
		wr_data.ticks   = rd_s1.ticks - odts_pkg::TICKS_W'(1);
		if (state_q == ST_IDLE) begin
			wr_addr = next_slot_q;
			rd_addr = next_slot_q;
			wr_data.task_id = head.task_id;
			wr_data.ticks   = head.ticks;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			next_slot_q <= '0;
			rd_ptr_q    <= '0;
			idx_s1      <= '0;
			issued_q    <= '0;
			hold_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (is_arm) begin
							active_q[next_slot_q] <= 1'b1;
							next_slot_q           <= slot_inc(next_slot_q);
						end else begin
							idx_s1   <= next_slot_q;
							rd_ptr_q <= slot_inc(next_slot_q);
							issued_q <= CNT_W'(1);
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (expire) begin
							active_q[idx_s1] <= 1'b0;
							hold_v_q         <= 1'b1;
						end
						if (scan_more) begin
							idx_s1   <= rd_ptr_q;
							rd_ptr_q <= slot_inc(rd_ptr_q);
							issued_q <= issued_q + CNT_W'(1);
						end else begin
							state_q <= (hold_v_q || expire) ? ST_FLUSH : ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_emit) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload: hold stage and output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_task_q <= hold_task_q;
			out_slot_q <= odts_pkg::SLOT_OUT_W'(hold_slot_q);
			out_last_q <= flush_emit;
		end
		if (scan_go && expire) begin
			hold_task_q <= rd_s1.task_id;
			hold_slot_q <= idx_s1;
		end
	end

	assign out_valid    = out_v_q;
	assign expired_task = out_task_q;
	assign expired_slot = out_slot_q;
	assign last_expiry  = out_last_q;

	`ASSERT_IMPL(a_idle_no_hold, clk, arst_n, state_q == ST_IDLE, !hold_v_q,
		"pending expiry left behind in idle")
	`ASSERT_NEXT(a_scan_ends, clk, arst_n, scan_go && !scan_more, state_q != ST_SCAN,
		"scan ran past the last slot")

endmodule

// ===== rtl/oneshot_delay_timer_slots.sv =====
// Top level of the one-shot delay timer bank.
// Depends on odts_pkg, odts_front, odts_queue and odts_back.
`timescale 1ns / 1ps

// Usage
//  Input channel (in_valid/in_ready): one beat per item. mode 1 arms the
//  next slot of the ring with task_id and delay_ticks (0 counts as 1);
//  mode 0 is one system tick. Ticks are dropped while timer_enable is 0.
//  Config channel (cfg_valid/cfg_ready): one beat writes timer_enable;
//  always ready, write it only while the block is quiet.
//  Output channel (out_valid/out_ready): one beat per expired slot, in ring
//  order from the oldest armed slot, last_expiry set on the final beat of
//  a tick.
//  Steps: an arm is taken from the queue and written to its slot. An enabled
//  tick is taken from the queue, then each slot in turn is read, decremented
//  and written back (one read and one write of the slot memory per cycle
//  unless stalled), then any last expiry is flushed. The first result passes
//  through the queue, the slot read register, the hold and output registers.
//  A small command queue lets new beats in while a tick is being scanned
//  or a result waits in the output register.
//  Reset: all slots inactive, ring pointer at slot zero, timer disabled,
//  queue empty, no result pending.
//  Receiver stall: output and hold registers keep their beats, the scan halts
//  on an expiry with the hold full, and input backs up once the queue fills.

module oneshot_delay_timer_slots #(
	parameter int NUM_SLOTS   = odts_pkg::NUM_SLOTS_DEF,
	parameter int QUEUE_DEPTH = odts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            timer_enable,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [odts_pkg::TASK_W-1:0]     task_id,
	input  logic [odts_pkg::TICKS_W-1:0]    delay_ticks,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [odts_pkg::TASK_W-1:0]     expired_task,
	output logic [odts_pkg::SLOT_OUT_W-1:0] expired_slot,
	output logic                            last_expiry
);

	// Command path between front end and slot engine
	odts_pkg::cmd_t    push_cmd;
	odts_pkg::cmd_t    head;
	odts_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	// Accept beats, hold the enable bit, drop disabled ticks
	odts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.timer_enable (timer_enable),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.task_id      (task_id),
		.delay_ticks  (delay_ticks),
		.q_stat       (q_stat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	// Decouple the two sides so each may stall on its own
	odts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Arm slots and scan them on each tick
	odts_back #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.expired_task (expired_task),
		.expired_slot (expired_slot),
		.last_expiry  (last_expiry)
	);

endmodule

// ===== tb/sv/oneshot_delay_timer_slots_tb.sv =====
// Self-checking testbench for the one-shot delay timer bank.
// Depends on odts_pkg and oneshot_delay_timer_slots; checks every expiry beat
// against a cycle-free model of the slot ring kept in the testbench, or a typed row.
`timescale 1ns / 1ps

module oneshot_delay_timer_slots_tb;

	typedef odts_pkg::op_t op_t;

	localparam op_t OP_TICK       = odts_pkg::OP_TICK;
	localparam op_t OP_ARM        = odts_pkg::OP_ARM;
	localparam int  TASK_W        = odts_pkg::TASK_W;
	localparam int  TICKS_W       = odts_pkg::TICKS_W;
	localparam int  SLOT_OUT_W    = odts_pkg::SLOT_OUT_W;

	localparam int SLOTS         = odts_pkg::NUM_SLOTS_DEF;
	// Quiet time after the last expected beat before a register write: a few
	// ticks with no expiry may still sit in the queue and the scan.
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 16;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_t;

	// One directed row: an input beat, or a write of timer_enable.
	// Where typed is set, the expiry (or its absence) is spelt out by hand.
	typedef struct packed {
		row_kind_t         kind;
		logic              en;
		op_t               op;
		logic [TASK_W-1:0]  tid;
		logic [TICKS_W-1:0] ticks;
		logic              typed;
		logic              hit;
		logic [TASK_W-1:0]  exp_task;
		logic [SLOT_OUT_W-1:0] exp_slot;
		logic              exp_last;
	} stim_row_t;

	typedef struct packed {
		logic [TASK_W-1:0]     task_id;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  last;
	} expiry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic timer_enable = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic [TASK_W-1:0] task_id = '0;
	logic [TICKS_W-1:0] delay_ticks = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TASK_W-1:0] expired_task;
	logic [SLOT_OUT_W-1:0] expired_slot;
	logic last_expiry;

	// Hand-typed expectation travelling with the input beat; driven like the
	// payload so the monitor sees it settled at the accepting edge.
	logic tag_typed = 1'b0;
	logic tag_hit = 1'b0;
	logic [TASK_W-1:0] tag_task = '0;
	logic [SLOT_OUT_W-1:0] tag_slot = '0;
	logic tag_last = 1'b0;

	// Model of the slot ring
	logic [TICKS_W-1:0] rem_ticks [SLOTS] = '{default: '0};
	logic [TASK_W-1:0] owner_id [SLOTS] = '{default: '0};
	bit slot_live [SLOTS] = '{default: 1'b0};
	int ring_ptr = 0;
	bit en_model = 1'b0;

	expiry_t fired_now [$];    // expiries raised by the beat just modelled
	expiry_t expiry_due_q [$]; // expiries still to be seen on the output, oldest first

	int err_count = 0;
	int quiet_cycles = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	bit hold_off = 1'b0;

	stim_row_t plan [23] = '{
		// disabled after reset: a tick does nothing
		'{ROW_ITEM, 1'b0, OP_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		// zero count lands in slot 0 and is held as one tick
		'{ROW_ITEM, 1'b0, OP_ARM,  8'hFF, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_CFG,  1'b1, OP_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_TICK, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 8'hFF, 4'd0, 1'b1},
		// largest count in slot 1, to be overwritten later
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h5A, 32'h0000_0001, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'hA5, 32'h0000_0002, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_TICK, 8'h3C, 32'h1234_5678, 1'b1, 1'b1, 8'h5A, 4'd2, 1'b1},
		'{ROW_ITEM, 1'b0, OP_TICK, 8'hC3, 32'h8765_4321, 1'b1, 1'b1, 8'hA5, 4'd3, 1'b1},
		// arm still works while disabled; the tick is dropped
		'{ROW_CFG,  1'b0, OP_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h11, 32'h0000_0001, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_TICK, 8'hFF, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_CFG,  1'b1, OP_TICK, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
		// wrap the ring; the last arm replaces the live long delay in slot 1
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h22, 32'h0000_0003, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h33, 32'h0000_0001, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h44, 32'h0000_0002, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h55, 32'h0000_0001, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h66, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h80, 32'h0000_0002, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_ARM,  8'h77, 32'h0000_0001, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0},
		// several expiries per tick, in ring order from the oldest slot
		'{ROW_ITEM, 1'b0, OP_TICK, 8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_TICK, 8'hFF, 32'h0000_0000, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0},
		'{ROW_ITEM, 1'b0, OP_TICK, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 8'h22, 4'd5, 1'b1}
	};

	oneshot_delay_timer_slots dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.timer_enable (timer_enable),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.task_id      (task_id),
		.delay_ticks  (delay_ticks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.expired_task (expired_task),
		.expired_slot (expired_slot),
		.last_expiry  (last_expiry)
	);

	always #5 clk = ~clk;

	// Apply one accepted beat to the ring model and collect the expiries it
	// raises into fired_now. Arms overwrite the slot under the pointer;
	// enabled ticks walk the whole ring starting at the oldest slot.
	function automatic void advance_timer_bank(op_t op, logic [TASK_W-1:0] tid,
			logic [TICKS_W-1:0] ticks);
		int s;
		fired_now.delete();
		if (op == OP_ARM) begin
			rem_ticks[ring_ptr] = (ticks == '0) ? TICKS_W'(1) : ticks;
			owner_id[ring_ptr] = tid;
			slot_live[ring_ptr] = 1'b1;
			ring_ptr = (ring_ptr + 1 == SLOTS) ? 0 : ring_ptr + 1;
		end else if (en_model) begin
			for (int k = 0; k < SLOTS; k++) begin
				s = ring_ptr + k;
				if (s >= SLOTS)
					s -= SLOTS;
				if (slot_live[s]) begin
					rem_ticks[s] = rem_ticks[s] - TICKS_W'(1);
					if (rem_ticks[s] == '0) begin
						slot_live[s] = 1'b0;
						fired_now.push_back('{owner_id[s], SLOT_OUT_W'(s), 1'b0});
					end
				end
			end
			if (fired_now.size() > 0)
				fired_now[fired_now.size() - 1].last = 1'b1;
		end
	endfunction

	// Monitor: sample every channel at the edge, before any update of this step
	// lands. Check output beats first, then track register writes and inputs.
	always @(posedge clk) begin
		expiry_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expiry_due_q.size() == 0) begin
					$error("unexpected expiry beat: task %0h slot %0d last %0b",
						expired_task, expired_slot, last_expiry);
					err_count++;
				end else begin
					want = expiry_due_q.pop_front();
					if (expired_task !== want.task_id) begin
						$error("expired_task: expected %0h, got %0h", want.task_id, expired_task);
						err_count++;
					end
					if (expired_slot !== want.slot) begin
						$error("expired_slot: expected %0d, got %0d", want.slot, expired_slot);
						err_count++;
					end
					if (last_expiry !== want.last) begin
						$error("last_expiry: expected %0b, got %0b", want.last, last_expiry);
						err_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				en_model = timer_enable;
			if (in_valid && in_ready) begin
				advance_timer_bank(op_t'(mode), task_id, delay_ticks);
				// a hand-typed row overrides the model's expiries, never its state
				if (tag_typed) begin
					if (tag_hit)
						expiry_due_q.push_back('{tag_task, tag_slot, tag_last});
				end else begin
					foreach (fired_now[i])
						expiry_due_q.push_back(fired_now[i]);
				end
			end
		end
	end

	// Watchdog: any beat on any channel resets the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: draw a stall before each beat, or honour one long hold-off on
	// request so the queue fills and the input backs up.
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				stall = rx_burst ? 0 : $urandom_range(0, 8);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid && !hold_off);
		end
	end

	// Offer one input beat after a drawn gap and hold it until taken. Leave
	// valid high on return so a back-to-back beat needs no second update.
	task automatic offer(input op_t op, input logic [TASK_W-1:0] tid,
			input logic [TICKS_W-1:0] ticks, input logic typed, input logic hit,
			input logic [TASK_W-1:0] et, input logic [SLOT_OUT_W-1:0] es,
			input logic el);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		task_id <= tid;
		delay_ticks <= ticks;
		tag_typed <= typed;
		tag_hit <= hit;
		tag_task <= et;
		tag_slot <= es;
		tag_last <= el;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait for every expected expiry, then let ticks that raise
	// nothing drain out of the queue and the scan.
	task automatic settle_all();
		in_valid <= 1'b0;
		do @(posedge clk); while (expiry_due_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(input logic en);
		cfg_valid <= 1'b1;
		timer_enable <= en;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random beat: mostly short delays so slots expire within a phase, now and
	// then a zero or a full-width count, and ticks with junk in the idle fields.
	task automatic offer_random(input int arm_pct);
		int pick;
		logic [TICKS_W-1:0] ticks;
		if ($urandom_range(0, 99) < arm_pct) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				ticks = $urandom();
			else if (pick == 1)
				ticks = '0;
			else
				ticks = TICKS_W'($urandom_range(1, 6));
			offer(OP_ARM, TASK_W'($urandom()), ticks, 1'b0, 1'b0, '0, '0, 1'b0);
		end else begin
			offer(OP_TICK, TASK_W'($urandom()), $urandom(), 1'b0, 1'b0, '0, '0, 1'b0);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows; a register write always waits for a quiet block
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle_all();
				write_enable(plan[i].en);
			end else begin
				offer(plan[i].op, plan[i].tid, plan[i].ticks, plan[i].typed, plan[i].hit,
					plan[i].exp_task, plan[i].exp_slot, plan[i].exp_last);
			end
		end

		// random phases, each opened with a register write on a quiet block
		for (int p = 0; p < 5; p++) begin
			settle_all();
			write_enable((p == 2) ? 1'b0 : 1'b1);
			tx_burst = (p == 1 || p == 4);
			rx_burst = (p == 3 || p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++)
				offer_random(60);
		end

		// pressure: fill every slot with a one-tick delay and tick while the
		// receiver holds off, so a full ring of expiries backs up into the input
		settle_all();
		write_enable(1'b1);
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		hold_off = 1'b1;
		for (int r = 0; r < 2; r++) begin
			for (int n = 0; n < SLOTS; n++)
				offer(OP_ARM, TASK_W'($urandom()), TICKS_W'($urandom_range(0, 1)),
					1'b0, 1'b0, '0, '0, 1'b0);
			offer(OP_TICK, TASK_W'($urandom()), $urandom(), 1'b0, 1'b0, '0, '0, 1'b0);
			offer(OP_TICK, TASK_W'($urandom()), $urandom(), 1'b0, 1'b0, '0, '0, 1'b0);
		end

		settle_all();
		if (err_count == 0 && expiry_due_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/odts_pkg.sv
rtl/odts_queue.sv
rtl/odts_front.sv
rtl/odts_back.sv
rtl/oneshot_delay_timer_slots.sv
tb/sv/oneshot_delay_timer_slots_tb.sv
